// ===== hw/rtl/spbs_pkg.sv =====
package spbs_pkg;

  localparam int unsigned ERR_W   = 18;
  localparam int unsigned SPEED_W = 16;
  localparam int unsigned CFG_DW  = 32;
  localparam int unsigned IDX_W   = 3;

  // magnitude ceiling of one PID term, Q.24
  localparam logic [63:0] TERM_LIMIT = 64'h1000_0000_0000_0000;

  localparam logic [31:0] RST_GAIN_PROP        = 32'd131072;
  localparam logic [31:0] RST_GAIN_INTEGRAL_DT = 32'd983;
  localparam logic [31:0] RST_GAIN_DERIV_RATE  = 32'd131072;
  localparam logic [14:0] RST_ACCEL_LIMIT      = 15'd512;
  localparam logic [31:0] RST_TORQUE_PER_ACCEL = 32'd7733248;
  localparam logic [15:0] RST_TORQUE_LIMIT     = 16'd51200;
  localparam logic [15:0] RST_TORQUE_DEADBAND  = 16'd3840;

  typedef enum logic [IDX_W-1:0] {
    REG_GAIN_PROP        = 3'd0,
    REG_GAIN_INTEGRAL_DT = 3'd1,
    REG_GAIN_DERIV_RATE  = 3'd2,
    REG_ACCEL_LIMIT      = 3'd3,
    REG_TORQUE_PER_ACCEL = 3'd4,
    REG_TORQUE_LIMIT     = 3'd5,
    REG_TORQUE_DEADBAND  = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    MUL_P = 2'd0,
    MUL_I = 2'd1,
    MUL_D = 2'd2,
    MUL_T = 2'd3
  } mul_sel_t;

  typedef struct packed {
    logic [31:0] gain_prop;
    logic [31:0] gain_integral_dt;
    logic [31:0] gain_deriv_rate;
    logic [14:0] accel_limit;
    logic [31:0] torque_per_accel;
    logic [15:0] torque_limit;
    logic [15:0] torque_deadband;
  } cfg_t;

  typedef struct packed {
    logic     capture;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     sum_clear;
    logic     sum_add;
    logic     state_upd;
    logic     accel_upd;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

// ===== hw/rtl/spbs_if.sv =====
interface spbs_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] target_speed;
  logic signed [15:0] current_speed;

  modport source (output valid, output target_speed, output current_speed, input ready);
  modport sink (input valid, input target_speed, input current_speed, output ready);
endinterface

interface spbs_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_command;
  logic        [15:0] drive_torque;
  logic        [15:0] brake_torque;
  logic               windup_reset;

  modport source (output valid, output accel_command, output drive_torque,
                  output brake_torque, output windup_reset, input ready);
  modport sink (input valid, input accel_command, input drive_torque,
                input brake_torque, input windup_reset, output ready);
endinterface

interface spbs_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/spbs_cfg.sv =====
module spbs_cfg (
  input  logic              clk,
  input  logic              rst,
  spbs_cfg_if.sink          cfg,
  output spbs_pkg::cfg_t    regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.gain_prop        <= spbs_pkg::RST_GAIN_PROP;
      regs.gain_integral_dt <= spbs_pkg::RST_GAIN_INTEGRAL_DT;
      regs.gain_deriv_rate  <= spbs_pkg::RST_GAIN_DERIV_RATE;
      regs.accel_limit      <= spbs_pkg::RST_ACCEL_LIMIT;
      regs.torque_per_accel <= spbs_pkg::RST_TORQUE_PER_ACCEL;
      regs.torque_limit     <= spbs_pkg::RST_TORQUE_LIMIT;
      regs.torque_deadband  <= spbs_pkg::RST_TORQUE_DEADBAND;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        spbs_pkg::REG_GAIN_PROP:        regs.gain_prop        <= cfg.data;
        spbs_pkg::REG_GAIN_INTEGRAL_DT: regs.gain_integral_dt <= cfg.data;
        spbs_pkg::REG_GAIN_DERIV_RATE:  regs.gain_deriv_rate  <= cfg.data;
        spbs_pkg::REG_ACCEL_LIMIT:      regs.accel_limit      <= cfg.data[14:0];
        spbs_pkg::REG_TORQUE_PER_ACCEL: regs.torque_per_accel <= cfg.data;
        spbs_pkg::REG_TORQUE_LIMIT:     regs.torque_limit     <= cfg.data[15:0];
        spbs_pkg::REG_TORQUE_DEADBAND:  regs.torque_deadband  <= cfg.data[15:0];
        default: ;  // unknown index: drop the write
      endcase
    end
  end

endmodule

// ===== hw/rtl/spbs_ctrl.sv =====
module spbs_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  spbs_pkg::dp_status_t   status,
  output spbs_pkg::dp_cmd_t      cmd
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MP   = 8'b0000_0010,
    S_MI   = 8'b0000_0100,
    S_MD   = 8'b0000_1000,
    S_AD   = 8'b0001_0000,
    S_AC   = 8'b0010_0000,
    S_MT   = 8'b0100_0000,
    S_TQ   = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.capture = req_valid;
        if (req_valid) state_next = S_MP;
      end
      S_MP: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = spbs_pkg::MUL_P;
        cmd.sum_clear = 1'b1;
        state_next    = S_MI;
      end
      S_MI: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = spbs_pkg::MUL_I;
        cmd.sum_add = 1'b1;
        state_next  = S_MD;
      end
      S_MD: begin
        // integral product is in the product register: windup check here
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = spbs_pkg::MUL_D;
        cmd.sum_add   = 1'b1;
        cmd.state_upd = 1'b1;
        state_next    = S_AD;
      end
      S_AD: begin
        cmd.sum_add = 1'b1;
        state_next  = S_AC;
      end
      S_AC: begin
        cmd.accel_upd = 1'b1;
        state_next    = S_MT;
      end
      S_MT: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = spbs_pkg::MUL_T;
        state_next  = S_TQ;
      end
      S_TQ: begin
        // hold until the output register is free
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hw/rtl/spbs_dp.sv =====
module spbs_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  spbs_pkg::cfg_t         regs,
  input  spbs_pkg::dp_cmd_t      cmd,
  output spbs_pkg::dp_status_t   status,
  input  logic signed [15:0]     target_speed,
  input  logic signed [15:0]     current_speed,
  spbs_out_if.source             rsp
);

  logic signed [16:0] tgt_abs;
  logic signed [17:0] err_next;
  logic signed [17:0] err;
  logic signed [17:0] prev_err;
  logic signed [31:0] acc;
  logic               err_nz;

  logic signed [32:0] isum;
  logic signed [18:0] dsum;
  logic        [31:0] err_mag;
  logic        [31:0] imag;
  logic        [31:0] dmag;
  logic        [31:0] amag;

  logic        [31:0] mul_a;
  logic        [31:0] mul_b;
  logic               mul_neg;
  logic        [63:0] prod;
  logic               prod_neg;
  logic        [63:0] prod_sat;
  logic signed [63:0] term;
  logic signed [63:0] sum;

  logic signed [31:0] acc_sat;
  logic        [63:0] acc_lim;
  logic               windup;
  logic               windup_flag;

  logic signed [63:0] lim_s;
  logic        [30:0] cmag;
  logic               cneg;
  logic        [31:0] arnd;
  logic signed [15:0] accel;

  logic        [63:0] tlim;
  logic        [31:0] tmag;
  logic        [32:0] trnd;
  logic        [15:0] tval;
  logic               tover;

  assign tgt_abs  = target_speed[15] ? -17'(target_speed) : 17'(target_speed);
  assign err_next = 18'(tgt_abs) - 18'(current_speed);
  assign err_nz   = (err != '0);

  assign isum = 33'(acc) + 33'(err);
  assign dsum = 19'(err) - 19'(prev_err);

  assign err_mag = err[17]   ? 32'(-err)   : 32'(err);
  assign imag    = isum[32]  ? 32'(-isum)  : 32'(isum);
  assign dmag    = dsum[18]  ? 32'(-dsum)  : 32'(dsum);
  assign amag    = accel[15] ? 32'(-accel) : 32'(accel);

  // operand select for the shared multiplier
  always_comb begin
    unique case (cmd.mul_sel)
      spbs_pkg::MUL_P: begin
        mul_a   = regs.gain_prop;
        mul_b   = err_mag;
        mul_neg = err[17];
      end
      spbs_pkg::MUL_I: begin
        mul_a   = regs.gain_integral_dt;
        mul_b   = err_nz ? imag : '0;
        mul_neg = isum[32];
      end
      spbs_pkg::MUL_D: begin
        mul_a   = regs.gain_deriv_rate;
        mul_b   = err_nz ? dmag : '0;
        mul_neg = dsum[18];
      end
      spbs_pkg::MUL_T: begin
        mul_a   = regs.torque_per_accel;
        mul_b   = amag;
        mul_neg = accel[15];
      end
      default: begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
      end
    endcase
  end

  assign prod_sat = (prod > spbs_pkg::TERM_LIMIT) ? spbs_pkg::TERM_LIMIT : prod;
  assign term     = prod_neg ? -$signed(prod_sat) : $signed(prod_sat);

  // saturating accumulator update and windup test on the integral term
  assign acc_sat = (isum[32] != isum[31]) ? (isum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                                          : isum[31:0];
  assign acc_lim = {33'b0, regs.accel_limit, 16'b0};
  assign windup  = (prod_sat > acc_lim);

  // clamp the PID sum to the acceleration limit, then round to Q8.8
  assign lim_s = $signed(acc_lim);
  always_comb begin
    if (sum > lim_s) begin
      cneg = 1'b0;
      cmag = acc_lim[30:0];
    end else if (sum < -lim_s) begin
      cneg = 1'b1;
      cmag = acc_lim[30:0];
    end else begin
      cneg = sum[63];
      cmag = sum[63] ? 31'(-sum) : 31'(sum);
    end
  end
  assign arnd = (32'(cmag) + 32'd32768) >> 16;

  // torque clamp, round and deadband split
  assign tlim  = {32'b0, regs.torque_limit, 16'b0};
  assign tmag  = (prod > tlim) ? tlim[31:0] : prod[31:0];
  assign trnd  = (33'(tmag) + 33'd32768) >> 16;
  assign tval  = trnd[15:0];
  assign tover = (tval > regs.torque_deadband);

  always_ff @(posedge clk) begin
    if (cmd.capture) err <= err_next;
    if (cmd.mul_en) begin
      prod     <= 64'(mul_a) * 64'(mul_b);
      prod_neg <= mul_neg;
    end
    if (cmd.sum_clear) begin
      sum <= '0;
    end else if (cmd.sum_add) begin
      sum <= sum + term;
    end
    if (cmd.state_upd) windup_flag <= windup;
    if (cmd.accel_upd) accel <= cneg ? -16'(arnd) : 16'(arnd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      prev_err <= '0;
    end else if (cmd.state_upd) begin
      acc      <= windup ? '0 : acc_sat;
      prev_err <= err;
    end
  end

  assign status.out_free = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.accel_command <= accel;
      rsp.drive_torque  <= (!prod_neg && tover) ? tval : '0;
      rsp.brake_torque  <= (prod_neg && tover) ? tval : '0;
      rsp.windup_reset  <= windup_flag;
    end
  end

endmodule

// ===== hw/rtl/speed_pid_drive_brake_split.sv =====
// Speed PID with drive/brake torque split. One transfer on req carries a
// target and a measured speed (Q8.8); one transfer on rsp returns the
// clamped acceleration, the drive or brake torque and the windup flag. An
// item is taken only while idle, and the next only once its result is
// loaded, which waits for a free output register. A single 32x32
// multiplier forms the proportional, integral, derivative and torque
// products one after another, with a clamp-and-round step between the PID
// sum and the torque product. A finished result waits in the output register
// while the next item is taken. Cfg ready is always high, and the user must
// write the registers only while idle; the block does not enforce this.
module speed_pid_drive_brake_split (
  input  logic        clk,
  input  logic        rst,
  spbs_in_if.sink     req,
  spbs_out_if.source  rsp,
  spbs_cfg_if.sink    cfg
);

  spbs_pkg::cfg_t       regs;
  spbs_pkg::dp_cmd_t    cmd;
  spbs_pkg::dp_status_t status;
  logic                 ready;

  assign req.ready = ready;

  spbs_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  spbs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (ready),
    .status    (status),
    .cmd       (cmd)
  );

  spbs_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .regs          (regs),
    .cmd           (cmd),
    .status        (status),
    .target_speed  (req.target_speed),
    .current_speed (req.current_speed),
    .rsp           (rsp)
  );

  // one item in flight: no new transfer right after one is taken
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (req.valid && ready) |=> !ready)
    else $error("input taken while an item is in flight");

  // never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!rsp.valid || rsp.ready))
    else $error("result register overwritten");

  a_split_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.drive_torque == 16'd0 || rsp.brake_torque == 16'd0))
    else $error("drive and brake both requested");

endmodule
